// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, disabled while the active-low reset is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

// File: rtl/core/svct_pkg.sv
// ---------------------------------------------------------------------------
// svct_pkg
// Types and constants of the sorted value count table.
// ---------------------------------------------------------------------------
package svct_pkg;

  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 32;
  localparam int STATUS_W = 3;

  localparam logic [STATUS_W-1:0] ST_MATCH   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ENTRY   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DUMP   = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic capture;
    logic apply;
    logic dump_step;
    logic dump_empty;
  } svct_cmd_t;

  typedef struct packed {
    logic out_free;
    logic dump_last;
    logic table_empty;
  } svct_sts_t;

endpackage

// File: rtl/core/svct_in_if.sv
// ---------------------------------------------------------------------------
// svct_in_if
// Command channel: insert or dump, with the value to count.
// ---------------------------------------------------------------------------
interface svct_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic signed [svct_pkg::VALUE_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

// File: rtl/core/svct_out_if.sv
// ---------------------------------------------------------------------------
// svct_out_if
// Result channel: status, entry value, entry count and last marker.
// ---------------------------------------------------------------------------
interface svct_out_if;
  logic                                valid;
  logic                                ready;
  logic [svct_pkg::STATUS_W-1:0]       status;
  logic signed [svct_pkg::VALUE_W-1:0] entry_value;
  logic [svct_pkg::COUNT_W-1:0]        entry_count;
  logic                                last;

  modport source (output valid, output status, output entry_value, output entry_count,
                  output last, input ready);
  modport sink (input valid, input status, input entry_value, input entry_count,
                input last, output ready);
endinterface

// File: rtl/core/sorted_value_count_table_core.sv
// ---------------------------------------------------------------------------
// sorted_value_count_table_core
// Ascending table of distinct signed values with saturating occurrence counts.
//
//   channel  dir  handshake    payload
//   in_ch    in   valid/ready  command, value
//   out_ch   out  valid/ready  status, entry_value, entry_count, last
//
// An insert compares against all cells in parallel, then shifts or counts
// and loads the result register. A dump gives one entry per cycle, while
// the result register is free, by rotating the cell row; an empty table
// gives one empty result. Items are taken one at a time.
// Reset empties the table at once; no clearing pass.
// A stalled result register holds the sequencer until the result transfers.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_value_count_table_core #(
  parameter int CAPACITY = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  svct_in_if.sink    in_ch,
  svct_out_if.source out_ch
);

  svct_pkg::svct_cmd_t cmd;
  svct_pkg::svct_sts_t sts;

  svct_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  svct_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_value        (in_ch.value),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_status      (out_ch.status),
    .out_entry_value (out_ch.entry_value),
    .out_entry_count (out_ch.entry_count),
    .out_last        (out_ch.last)
  );

  `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  `ASSERT_IMPL(a_dump_holds_input, clk, rst_n, out_ch.valid && !out_ch.last, !in_ch.ready)
  `ASSERT_IMPL(a_load_when_free, clk, rst_n, cmd.apply || cmd.dump_step || cmd.dump_empty, sts.out_free)
  `ASSERT_IMPL(a_single_command, clk, rst_n, 1'b1, $onehot0(cmd))

endmodule

// File: rtl/core/svct_ctrl.sv
// ---------------------------------------------------------------------------
// svct_ctrl
// Controller: accepts commands and sequences insert updates and dumps.
// ---------------------------------------------------------------------------
module svct_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_command,
  output logic                in_ready,
  output svct_pkg::svct_cmd_t cmd,
  input  svct_pkg::svct_sts_t sts
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INS  = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    cmd            = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_command == svct_pkg::CMD_DUMP) ? S_DUMP : S_INS;
        end
      end
      S_INS: begin
        if (sts.out_free) begin
          cmd.apply = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DUMP: begin
        if (sts.out_free) begin
          if (sts.table_empty) begin
            cmd.dump_empty = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            cmd.dump_step = 1'b1;
            if (sts.dump_last) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/core/svct_dp.sv
// ---------------------------------------------------------------------------
// svct_dp
// Datapath: sorted cell row with parallel compare, shift insert, rotate dump
// and the result register.
// ---------------------------------------------------------------------------
module svct_dp #(
  parameter int CAPACITY = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  svct_pkg::svct_cmd_t                 cmd,
  output svct_pkg::svct_sts_t                 sts,
  input  logic signed [svct_pkg::VALUE_W-1:0] in_value,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [svct_pkg::STATUS_W-1:0]       out_status,
  output logic signed [svct_pkg::VALUE_W-1:0] out_entry_value,
  output logic [svct_pkg::COUNT_W-1:0]        out_entry_count,
  output logic                                out_last
);

  localparam int OW = $clog2(CAPACITY + 1);

  logic signed [svct_pkg::VALUE_W-1:0] cell_val_r [CAPACITY];
  logic [svct_pkg::COUNT_W-1:0]        cell_cnt_r [CAPACITY];

  logic [OW-1:0]                       occ_r;
  logic [OW-1:0]                       dump_cnt_r;
  logic signed [svct_pkg::VALUE_W-1:0] val_r;
  logic [CAPACITY-1:0]                 lt_r;
  logic [CAPACITY-1:0]                 eq_r;

  logic                                out_valid_r;
  logic [svct_pkg::STATUS_W-1:0]       out_status_r;
  logic signed [svct_pkg::VALUE_W-1:0] out_value_r;
  logic [svct_pkg::COUNT_W-1:0]        out_count_r;
  logic                                out_last_r;

  logic                                any_eq;
  logic                                full;
  logic                                add_new;
  logic [svct_pkg::COUNT_W-1:0]        match_cnt;
  logic [svct_pkg::COUNT_W-1:0]        match_inc;
  logic [CAPACITY-1:0]                 ins_here;
  logic [CAPACITY-1:0]                 shift_here;
  logic [CAPACITY-1:0]                 occ_mask;

  assign any_eq  = |eq_r;
  assign full    = (occ_r == OW'(CAPACITY));
  assign add_new = cmd.apply && !any_eq && !full;

  always_comb begin
    match_cnt = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match_cnt = match_cnt | (eq_r[i] ? cell_cnt_r[i] : '0);
    end
  end

  assign match_inc = (match_cnt == svct_pkg::COUNT_MAX) ? match_cnt
                                                       : match_cnt + svct_pkg::COUNT_W'(1);

  assign sts.out_free    = !out_valid_r || out_ready;
  assign sts.dump_last   = ((dump_cnt_r + OW'(1)) == occ_r);
  assign sts.table_empty = (occ_r == '0);

  // per-cell compare, insert and rotate
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ_mask[i] = (OW'(i) < occ_r);

    if (i == 0) begin : g_first
      assign ins_here[i]   = !lt_r[i];
      assign shift_here[i] = 1'b0;
    end else begin : g_rest
      assign ins_here[i]   = !lt_r[i] && lt_r[i-1];
      assign shift_here[i] = !lt_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (cmd.capture) begin
        lt_r[i] <= occ_mask[i] && (cell_val_r[i] < in_value);
        eq_r[i] <= occ_mask[i] && (cell_val_r[i] == in_value);
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.apply && eq_r[i]) begin
        cell_cnt_r[i] <= match_inc;
      end else if (add_new && ins_here[i]) begin
        cell_val_r[i] <= val_r;
        cell_cnt_r[i] <= svct_pkg::COUNT_W'(1);
      end else if (add_new && shift_here[i]) begin
        if (i > 0) begin
          cell_val_r[i] <= cell_val_r[(i == 0) ? 0 : i - 1];
          cell_cnt_r[i] <= cell_cnt_r[(i == 0) ? 0 : i - 1];
        end
      end else if (cmd.dump_step) begin
        if ((i == CAPACITY - 1) || (occ_r == OW'(i + 1))) begin
          cell_val_r[i] <= cell_val_r[0];
          cell_cnt_r[i] <= cell_cnt_r[0];
        end else begin
          cell_val_r[i] <= cell_val_r[(i == CAPACITY - 1) ? 0 : i + 1];
          cell_cnt_r[i] <= cell_cnt_r[(i == CAPACITY - 1) ? 0 : i + 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      val_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r      <= '0;
      dump_cnt_r <= '0;
    end else begin
      if (add_new) begin
        occ_r <= occ_r + OW'(1);
      end
      if (cmd.capture) begin
        dump_cnt_r <= '0;
      end else if (cmd.dump_step) begin
        dump_cnt_r <= dump_cnt_r + OW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.apply || cmd.dump_step || cmd.dump_empty) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      out_value_r <= val_r;
      out_last_r  <= 1'b1;
      if (any_eq) begin
        out_status_r <= svct_pkg::ST_MATCH;
        out_count_r  <= match_inc;
      end else if (full) begin
        out_status_r <= svct_pkg::ST_DROPPED;
        out_count_r  <= '0;
      end else begin
        out_status_r <= svct_pkg::ST_ADDED;
        out_count_r  <= svct_pkg::COUNT_W'(1);
      end
    end else if (cmd.dump_step) begin
      out_status_r <= svct_pkg::ST_ENTRY;
      out_value_r  <= cell_val_r[0];
      out_count_r  <= cell_cnt_r[0];
      out_last_r   <= sts.dump_last;
    end else if (cmd.dump_empty) begin
      out_status_r <= svct_pkg::ST_EMPTY;
      out_value_r  <= '0;
      out_count_r  <= '0;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_value = out_value_r;
  assign out_entry_count = out_count_r;
  assign out_last        = out_last_r;

endmodule

// File: verif/sorted_value_count_table_core_tb.sv
// ---------------------------------------------------------------------------
// sorted_value_count_table_core_tb
// Self-checking bench for the sorted value count table. A tally of the table
// follows every accepted command and lines up the results that the block
// owes. Each result transfer is checked field by field against the oldest
// one. Stimulus is a directed opening, then random inserts and dumps that
// fill the table to capacity. Both channels stall in random bursts.
// ---------------------------------------------------------------------------
module sorted_value_count_table_core_tb;

  localparam int TABLE_DEPTH    = 32;
  localparam int RANDOM_ITEMS   = 356;
  localparam int QUIET_ITEMS    = 60;
  localparam int POOL_SIZE      = 40;
  localparam int DRAIN_CYCLES   = 2 * TABLE_DEPTH + 8;
  localparam int LIMIT_CYCLES   = 1000000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [svct_pkg::STATUS_W-1:0]       status;
    logic signed [svct_pkg::VALUE_W-1:0] value;
    logic [svct_pkg::COUNT_W-1:0]        count;
    logic                                last;
  } table_result_t;

  class sorted_tally_checker;
    logic signed [svct_pkg::VALUE_W-1:0] vals[TABLE_DEPTH];
    logic [svct_pkg::COUNT_W-1:0]        cnts[TABLE_DEPTH];
    int unsigned                         occ;
    table_result_t                       due_results[$];
    int unsigned                         failures;

    function void flag(string what, table_result_t exp_r, table_result_t got_r);
      failures++;
      if (failures <= REPORT_LIMIT) begin
        $display("%s: exp st %0d val %0d cnt %0d last %0d, got st %0d val %0d cnt %0d last %0d",
                 what, exp_r.status, exp_r.value, exp_r.count, exp_r.last,
                 got_r.status, got_r.value, got_r.count, got_r.last);
      end
    endfunction

    // Advance the tally by one accepted command and queue what it owes.
    function void take_command(logic cmd, logic signed [svct_pkg::VALUE_W-1:0] val);
      int unsigned pos;
      int unsigned i;
      if (cmd == svct_pkg::CMD_DUMP) begin
        if (occ == 0) begin
          due_results.push_back('{status: svct_pkg::ST_EMPTY, value: '0, count: '0,
                                  last: 1'b1});
        end else begin
          for (i = 0; i < occ; i++) begin
            due_results.push_back('{status: svct_pkg::ST_ENTRY, value: vals[i],
                                    count: cnts[i], last: (i + 1 == occ)});
          end
        end
        return;
      end
      pos = 0;
      while (pos < occ && vals[pos] < val) pos++;
      if (pos < occ && vals[pos] == val) begin
        if (cnts[pos] != svct_pkg::COUNT_MAX) cnts[pos] = cnts[pos] + 1;
        due_results.push_back('{status: svct_pkg::ST_MATCH, value: val, count: cnts[pos],
                                last: 1'b1});
      end else if (occ >= TABLE_DEPTH) begin
        due_results.push_back('{status: svct_pkg::ST_DROPPED, value: val, count: '0,
                                last: 1'b1});
      end else begin
        for (i = occ; i > pos; i--) begin
          vals[i] = vals[i-1];
          cnts[i] = cnts[i-1];
        end
        vals[pos] = val;
        cnts[pos] = 1;
        occ++;
        due_results.push_back('{status: svct_pkg::ST_ADDED, value: val, count: 1,
                                last: 1'b1});
      end
    endfunction

    function void check_result(table_result_t got_r);
      table_result_t exp_r;
      if (due_results.size() == 0) begin
        flag("unexpected result", '0, got_r);
        return;
      end
      exp_r = due_results.pop_front();
      if (got_r !== exp_r) flag("result mismatch", exp_r, got_r);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   idle_on;
  int unsigned cycles;
  logic signed [svct_pkg::VALUE_W-1:0] pool[POOL_SIZE];

  sorted_tally_checker tally = new();

  svct_in_if  in_if ();
  svct_out_if out_if ();

  sorted_value_count_table_core #(
    .CAPACITY(TABLE_DEPTH)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("sorted_value_count_table_core_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) tally.take_command(in_if.command, in_if.value);
      if (out_if.valid && out_if.ready) begin
        tally.check_result('{status: out_if.status, value: out_if.entry_value,
                             count: out_if.entry_count, last: out_if.last});
      end
    end
  end

  // result side: hold ready low in random bursts while idling is on
  initial begin
    out_if.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_if.ready = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      out_if.ready = 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  end

  task automatic send_command(input logic cmd,
                              input logic signed [svct_pkg::VALUE_W-1:0] val);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_if.valid   = 1'b1;
    in_if.command = cmd;
    in_if.value   = val;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  function automatic logic signed [svct_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed(32'($urandom_range(0, 4))) - 2;
      3, 4: return $signed($urandom());
      default: return pool[$urandom_range(0, POOL_SIZE - 1)];
    endcase
  endfunction

  initial begin
    rst_n          = 1'b0;
    idle_on        = 1'b1;
    cycles         = 0;
    in_if.valid    = 1'b0;
    in_if.command  = svct_pkg::CMD_INSERT;
    in_if.value    = '0;
    foreach (pool[k]) pool[k] = $signed($urandom());
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    send_command(svct_pkg::CMD_DUMP, 32'sh1234_5678);
    send_command(svct_pkg::CMD_INSERT, 32'sh0000_0000);
    send_command(svct_pkg::CMD_INSERT, 32'sh8000_0000);
    send_command(svct_pkg::CMD_INSERT, 32'sh7fff_ffff);
    send_command(svct_pkg::CMD_INSERT, -32'sd1);
    send_command(svct_pkg::CMD_INSERT, 32'sh0000_0000);
    send_command(svct_pkg::CMD_INSERT, 32'sh7fff_ffff);
    send_command(svct_pkg::CMD_INSERT, 32'sh8000_0000);
    send_command(svct_pkg::CMD_INSERT, 32'sh0000_0001);
    send_command(svct_pkg::CMD_INSERT, 32'sh5555_5555);
    send_command(svct_pkg::CMD_INSERT, 32'shaaaa_aaaa);
    send_command(svct_pkg::CMD_INSERT, -32'sd1);
    send_command(svct_pkg::CMD_DUMP, '0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_ITEMS) idle_on = 1'b0;
      if ($urandom_range(0, 9) == 0) send_command(svct_pkg::CMD_DUMP, $signed($urandom()));
      else send_command(svct_pkg::CMD_INSERT, pick_value());
    end
    send_command(svct_pkg::CMD_DUMP, '0);

    while (tally.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tally.failures == 0 && tally.due_results.size() == 0) begin
      $display("sorted_value_count_table_core_tb: done, clean");
    end else begin
      $display("sorted_value_count_table_core_tb: done, errors");
    end
    $finish;
  end

endmodule
